>>> rtl/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg
// Types and constants shared by the grace period tracker.
// ----------------------------------------------------------------------------
package rgp_pkg;

   localparam int ACTION_W   = 3;
   localparam int CPU_W      = 5;
   localparam int MASK_W     = 8;
   localparam int SEQ_W      = 32;
   localparam int BLK_W      = 8;
   localparam int REL_W      = 16;
   localparam int WOKEN_W    = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int Q_DEPTH    = 2;

   localparam logic [ACTION_W-1:0] ACT_SWITCH = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_EXIT   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ENQ    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SYNC   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd5;

   localparam logic CSR_IDX_MASK = 1'b0;

   typedef enum logic [2:0] {
      OP_SWITCH,
      OP_EXIT,
      OP_ENQ,
      OP_CHECK,
      OP_SYNC,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CPU_W-1:0] cpu;
      logic             in_reader;
      logic             already_blocked;
   } entry_type;

endpackage

>>> rtl/rgp_if.sv
// ----------------------------------------------------------------------------
// rgp_if
// Event and result channels of the grace period tracker.
// ----------------------------------------------------------------------------
interface rgp_req_if;
   import rgp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CPU_W-1:0]    cpu;
   logic                in_reader;
   logic                already_blocked;

   modport source (output valid, action, cpu, in_reader, already_blocked, input ready);
   modport sink   (input valid, action, cpu, in_reader, already_blocked, output ready);
endinterface

interface rgp_rsp_if;
   import rgp_pkg::*;
   logic               valid;
   logic               ready;
   logic [SEQ_W-1:0]   grace_sequence;
   logic               period_active;
   logic               period_ended;
   logic [MASK_W-1:0]  owed_mask;
   logic [BLK_W-1:0]   blocked_readers;
   logic               reader_now_blocked;
   logic [REL_W-1:0]   callbacks_released;
   logic [WOKEN_W-1:0] waiters_woken;

   modport source (output valid, grace_sequence, period_active, period_ended, owed_mask,
                   blocked_readers, reader_now_blocked, callbacks_released, waiters_woken,
                   input ready);
   modport sink   (input valid, grace_sequence, period_active, period_ended, owed_mask,
                   blocked_readers, reader_now_blocked, callbacks_released, waiters_woken,
                   output ready);
endinterface

>>> rtl/rgp_front.sv
// ----------------------------------------------------------------------------
// rgp_front
// Accepts event words, zeroes an out-of-range CPU index, decodes the action.
// ----------------------------------------------------------------------------
module rgp_front #(
   parameter int CPUS = 8
) (
   rgp_req_if.sink               req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output rgp_pkg::entry_type    q_wdata
);
   import rgp_pkg::*;

   op_type op;

   always_comb begin
      case (req_chan.action)
         ACT_SWITCH: op = OP_SWITCH;
         ACT_EXIT:   op = OP_EXIT;
         ACT_ENQ:    op = OP_ENQ;
         ACT_CHECK:  op = OP_CHECK;
         ACT_SYNC:   op = OP_SYNC;
         ACT_TICK:   op = OP_TICK;
         default:    op = OP_NONE;
      endcase
   end

   assign req_chan.ready          = !q_full;
   assign q_push                  = req_chan.valid && !q_full;
   assign q_wdata.op              = op;
   assign q_wdata.cpu             = (32'(req_chan.cpu) >= 32'(CPUS)) ? '0 : req_chan.cpu;
   assign q_wdata.in_reader       = req_chan.in_reader;
   assign q_wdata.already_blocked = req_chan.already_blocked;

endmodule

>>> rtl/rgp_queue.sv
// ----------------------------------------------------------------------------
// rgp_queue
// Two-entry queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module rgp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rgp_pkg::entry_type wdata,
   input  logic               pop,
   output logic               full,
   output logic               nonempty,
   output rgp_pkg::entry_type rdata
);
   import rgp_pkg::*;

   entry_type mem [Q_DEPTH];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   assign full     = (count_ff == 2'(Q_DEPTH));
   assign nonempty = (count_ff != '0);
   assign rdata    = mem[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> nonempty)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(Q_DEPTH))
      else $error("queue count out of range");

endmodule

>>> rtl/rgp_back.sv
// ----------------------------------------------------------------------------
// rgp_back
// Executes events: grace period state, per-CPU callback stages swept one
// CPU per cycle, and the result register.
// ----------------------------------------------------------------------------
module rgp_back #(
   parameter int CPUS        = 8,
   parameter int COUNT_BITS  = 16,
   parameter int WAITER_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_nonempty,
   input  rgp_pkg::entry_type          q_rdata,
   output logic                        q_pop,
   input  logic [rgp_pkg::MASK_W-1:0]  active_cpu_mask,
   rgp_rsp_if.source                   rsp_chan
);
   import rgp_pkg::*;

   localparam int IDX_W = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int ACC_W = (COUNT_BITS > REL_W) ? COUNT_BITS + 1 : REL_W + 1;
   localparam logic [MASK_W-1:0] VALID_MASK =
      (CPUS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << CPUS) - 64'd1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CPUS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DONE,
      ST_TICK,
      ST_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [MASK_W-1:0]      owed_ff, owed_in;
   logic [CPUS-1:0]        pend_ff, pend_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic [WAITER_BITS-1:0] sw_ff, sw_in;
   logic [WAITER_BITS-1:0] sr_ff, sr_in;
   logic                   rel_due_ff, rel_due_in;
   logic [COUNT_BITS-1:0]  next_ff [CPUS];
   logic [COUNT_BITS-1:0]  next_in [CPUS];
   logic [COUNT_BITS-1:0]  wait_ff [CPUS];
   logic [COUNT_BITS-1:0]  wait_in [CPUS];
   logic [COUNT_BITS-1:0]  done_ff [CPUS];
   logic [COUNT_BITS-1:0]  done_in [CPUS];
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   chain_ff, chain_in;
   logic                   ended_ff, ended_in;
   logic                   nowblk_ff, nowblk_in;
   logic [REL_W-1:0]       acc_ff, acc_in;
   logic [WAITER_BITS-1:0] woken_ff, woken_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]       rsp_seq_ff, rsp_seq_in;
   logic                   rsp_ended_ff, rsp_ended_in;
   logic [MASK_W-1:0]      rsp_owed_ff, rsp_owed_in;
   logic [BLK_W-1:0]       rsp_blk_ff, rsp_blk_in;
   logic                   rsp_nowblk_ff, rsp_nowblk_in;
   logic [REL_W-1:0]       rsp_rel_ff, rsp_rel_in;
   logic [WOKEN_W-1:0]     rsp_woken_ff, rsp_woken_in;

   always_comb begin
      logic [IDX_W-1:0]       cidx;
      logic                   owed_hit;
      logic [MASK_W-1:0]      owed_new;
      logic [BLK_W-1:0]       blk_dec;
      logic                   go_start;
      logic                   go_done;
      logic                   chain_hit;
      logic [COUNT_BITS:0]    csum;
      logic [WAITER_BITS:0]   wsum;
      logic [ACC_W-1:0]       asum;
      logic [15:0]            woken16;

      state_in      = state_ff;
      seq_in        = seq_ff;
      owed_in       = owed_ff;
      pend_in       = pend_ff;
      blk_in        = blk_ff;
      sw_in         = sw_ff;
      sr_in         = sr_ff;
      rel_due_in    = rel_due_ff;
      next_in       = next_ff;
      wait_in       = wait_ff;
      done_in       = done_ff;
      idx_in        = idx_ff;
      chain_in      = chain_ff;
      ended_in      = ended_ff;
      nowblk_in     = nowblk_ff;
      acc_in        = acc_ff;
      woken_in      = woken_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_seq_in    = rsp_seq_ff;
      rsp_ended_in  = rsp_ended_ff;
      rsp_owed_in   = rsp_owed_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_nowblk_in = rsp_nowblk_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_woken_in  = rsp_woken_ff;
      q_pop         = 1'b0;
      cidx          = q_rdata.cpu[IDX_W-1:0];
      owed_hit      = (q_rdata.cpu < CPU_W'(MASK_W)) ? owed_ff[q_rdata.cpu[2:0]] : 1'b0;
      owed_new      = owed_ff & ~(MASK_W'(1) << q_rdata.cpu[2:0]);
      blk_dec       = (blk_ff != '0) ? blk_ff - BLK_W'(1) : blk_ff;
      go_start      = 1'b0;
      go_done       = 1'b0;
      chain_hit     = 1'b0;
      csum          = '0;
      wsum          = '0;
      asum          = '0;
      woken16       = 16'(woken_ff);

      case (state_ff)
         ST_IDLE: begin
            if (q_nonempty) begin
               q_pop     = 1'b1;
               ended_in  = 1'b0;
               nowblk_in = 1'b0;
               acc_in    = '0;
               woken_in  = '0;
               state_in  = ST_RESP;
               case (q_rdata.op)
                  OP_SWITCH: begin
                     if (q_rdata.in_reader) begin
                        if (!q_rdata.already_blocked) begin
                           blk_in    = (blk_ff == '1) ? blk_ff : blk_ff + BLK_W'(1);
                           nowblk_in = 1'b1;
                        end
                     end else if (pend_ff[cidx]) begin
                        pend_in[cidx] = 1'b0;
                        if (owed_hit) begin
                           owed_in = owed_new;
                           go_done = (owed_new == '0) && (blk_ff == '0) && seq_ff[0];
                        end
                     end
                  end
                  OP_EXIT: begin
                     blk_in  = blk_dec;
                     go_done = (owed_ff == '0) && (blk_dec == '0) && seq_ff[0];
                  end
                  OP_ENQ: begin
                     csum          = {1'b0, next_ff[cidx]} + (COUNT_BITS+1)'(1);
                     next_in[cidx] = csum[COUNT_BITS] ? '1 : csum[COUNT_BITS-1:0];
                     go_start      = !seq_ff[0];
                  end
                  OP_CHECK: begin
                     go_start = ((next_ff[cidx] != '0) || (wait_ff[cidx] != '0)) && !seq_ff[0];
                  end
                  OP_SYNC: begin
                     wsum     = {1'b0, sw_ff} + (WAITER_BITS+1)'(1);
                     sw_in    = wsum[WAITER_BITS] ? '1 : wsum[WAITER_BITS-1:0];
                     go_start = !seq_ff[0];
                  end
                  OP_TICK: begin
                     if (rel_due_ff) begin
                        rel_due_in = 1'b0;
                        woken_in   = sr_ff;
                        sr_in      = '0;
                        idx_in     = '0;
                        state_in   = ST_TICK;
                     end
                  end
                  default: begin
                  end
               endcase
               if (go_done) begin
                  seq_in     = seq_ff + SEQ_W'(1);
                  ended_in   = 1'b1;
                  wsum       = {1'b0, sr_ff} + {1'b0, sw_ff};
                  sr_in      = wsum[WAITER_BITS] ? '1 : wsum[WAITER_BITS-1:0];
                  sw_in      = '0;
                  rel_due_in = 1'b1;
                  chain_in   = 1'b0;
                  idx_in     = '0;
                  state_in   = ST_DONE;
               end
               if (go_start) begin
                  seq_in   = seq_ff + SEQ_W'(1);
                  owed_in  = active_cpu_mask & VALID_MASK;
                  pend_in  = '1;
                  idx_in   = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            csum            = {1'b0, wait_ff[idx_ff]} + {1'b0, next_ff[idx_ff]};
            wait_in[idx_ff] = csum[COUNT_BITS] ? '1 : csum[COUNT_BITS-1:0];
            next_in[idx_ff] = '0;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            csum            = {1'b0, done_ff[idx_ff]} + {1'b0, wait_ff[idx_ff]};
            done_in[idx_ff] = csum[COUNT_BITS] ? '1 : csum[COUNT_BITS-1:0];
            wait_in[idx_ff] = '0;
            chain_hit       = chain_ff || (next_ff[idx_ff] != '0);
            chain_in        = chain_hit;
            if (idx_ff == LAST_IDX) begin
               if (chain_hit) begin
                  seq_in   = seq_ff + SEQ_W'(1);
                  owed_in  = active_cpu_mask & VALID_MASK;
                  pend_in  = '1;
                  idx_in   = '0;
                  state_in = ST_START;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_TICK: begin
            asum            = ACC_W'(acc_ff) + ACC_W'(done_ff[idx_ff]);
            acc_in          = (asum > ACC_W'({REL_W{1'b1}})) ? '1 : asum[REL_W-1:0];
            done_in[idx_ff] = '0;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_seq_in    = seq_ff;
               rsp_ended_in  = ended_ff;
               rsp_owed_in   = owed_ff;
               rsp_blk_in    = blk_ff;
               rsp_nowblk_in = nowblk_ff;
               rsp_rel_in    = acc_ff;
               rsp_woken_in  = woken16[WOKEN_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         owed_ff      <= '0;
         pend_ff      <= '0;
         blk_ff       <= '0;
         sw_ff        <= '0;
         sr_ff        <= '0;
         rel_due_ff   <= 1'b0;
         idx_ff       <= '0;
         chain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CPUS; i++) begin
            next_ff[i] <= '0;
            wait_ff[i] <= '0;
            done_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         owed_ff      <= owed_in;
         pend_ff      <= pend_in;
         blk_ff       <= blk_in;
         sw_ff        <= sw_in;
         sr_ff        <= sr_in;
         rel_due_ff   <= rel_due_in;
         idx_ff       <= idx_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         next_ff      <= next_in;
         wait_ff      <= wait_in;
         done_ff      <= done_in;
      end
      ended_ff      <= ended_in;
      nowblk_ff     <= nowblk_in;
      acc_ff        <= acc_in;
      woken_ff      <= woken_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_ended_ff  <= rsp_ended_in;
      rsp_owed_ff   <= rsp_owed_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_nowblk_ff <= rsp_nowblk_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_woken_ff  <= rsp_woken_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.grace_sequence     = rsp_seq_ff;
   assign rsp_chan.period_active      = rsp_seq_ff[0];
   assign rsp_chan.period_ended       = rsp_ended_ff;
   assign rsp_chan.owed_mask          = rsp_owed_ff;
   assign rsp_chan.blocked_readers    = rsp_blk_ff;
   assign rsp_chan.reader_now_blocked = rsp_nowblk_ff;
   assign rsp_chan.callbacks_released = rsp_rel_ff;
   assign rsp_chan.waiters_woken      = rsp_woken_ff;

   a_owed_active: assert property (@(posedge clock) disable iff (reset)
      (owed_ff != '0) |-> seq_ff[0])
      else $error("CPUs owed outside a grace period");
   a_start_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> seq_ff[0])
      else $error("start sweep with no active period");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !seq_ff[0] && rel_due_ff)
      else $error("completion sweep with period still active");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("event taken while busy");

endmodule

>>> rtl/rcu_grace_period_tracker.sv
// ----------------------------------------------------------------------------
// rcu_grace_period_tracker
// Preemptible RCU grace period tracker: decode front, event queue and a
// sequencing back end with per-CPU callback stage counts.
//
//   channel   dir   handshake            payload
//   req_chan  in    valid/ready          action, cpu, in_reader, already_blocked
//   rsp_chan  out   valid/ready          sequence, owed mask, counts, flags
//   csr_*     in    APB, pready tied 1   active_cpu_mask at byte address 0
//
// A period start, completion or tick release also sweeps over all CPUs (a
// chaining completion adds a start sweep). Sweeps go through one per-CPU
// counter entry per cycle. Synchronous reset clears control state and
// counters but not the result payload; active_cpu_mask resets to all ones.
// Requests queue in a two-word buffer; a stalled result holds the back end.
// ----------------------------------------------------------------------------
module rcu_grace_period_tracker #(
   parameter int CPUS        = 8,
   parameter int COUNT_BITS  = 16,
   parameter int WAITER_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   rgp_req_if.sink                          req_chan,
   rgp_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rgp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rgp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rgp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import rgp_pkg::*;

   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_nonempty;
   entry_type         q_wdata;
   entry_type         q_rdata;

   always_comb begin
      mask_in = mask_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_MASK)) begin
         mask_in = csr_pwdata[MASK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '1;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MASK) ? CSR_DATA_W'(mask_ff) : '0;

   rgp_front #(.CPUS(CPUS)) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   rgp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wdata    (q_wdata),
      .pop      (q_pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .rdata    (q_rdata)
   );

   rgp_back #(
      .CPUS        (CPUS),
      .COUNT_BITS  (COUNT_BITS),
      .WAITER_BITS (WAITER_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_nonempty      (q_nonempty),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .active_cpu_mask (mask_ff),
      .rsp_chan        (rsp_chan)
   );

endmodule
